// ===== rtl/ugns_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the uniform grid neighbor search block.
// Used by the top level and ugns_dist; depends on nothing.
package ugns_pkg;

	localparam int GRID_DEF      = 16;
	localparam int PARTICLES_DEF = 1024;
	localparam int NEIGHBORS_DEF = 64;

	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 88;

	localparam int IDX_W  = 10;
	localparam int CELL_W = 12;
	localparam int CNT_W  = 11;
	localparam int OCC_W  = 13;

	typedef enum logic [1:0] {
		FUNC_CLEAR = 2'd0,
		FUNC_ADD   = 2'd1,
		FUNC_QUERY = 2'd2,
		FUNC_STATS = 2'd3
	} func_t;

	typedef struct packed {
		logic signed [15:0] z;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} coord_t;

	typedef struct packed {
		logic              pad;
		logic [14:0]       search_radius;
		coord_t            pos;
	} in_data_t;

	typedef struct packed {
		logic [6:0]        pad;
		logic [CNT_W-1:0]  smallest_cell;
		logic [CNT_W-1:0]  largest_cell;
		logic [CNT_W-1:0]  binned_particles;
		logic [OCC_W-1:0]  used_cells;
		logic              in_grid;
		logic [CELL_W-1:0] cell_index;
		logic              store_full;
		logic [IDX_W-1:0]  new_index;
		logic              overflow;
		logic [IDX_W-1:0]  neighbor_index;
	} out_data_t;

endpackage

// ===== rtl/uniform_grid_neighbor_search.sv =====
`timescale 1ns / 1ps
// Uniform grid neighbor search top level. Depends on ugns_pkg, ugns_ram, ugns_dist.
//
// One operation runs at a time; s_axis_tready is high only while the block is idle.
// After reset a clearing pass over all G^3 cells zeroes the cell table before the first
// transfer is taken, and a clear operation repeats that pass. An add in the grid reads
// its cell and then writes it back; statistics sweep the cell table through its single
// read port. A query inside the grid walks the cells of its stencil, one outside it scans
// every stored particle, and each particle examined goes through position read, squaring
// and compare. The hits are buffered so that the overflow flag is known on the first
// result. The cell table, particle positions, list links and hit buffer each live in a
// RAM with a registered read.
module uniform_grid_neighbor_search #(
	parameter int GRID_CELLS_PER_AXIS = ugns_pkg::GRID_DEF,
	parameter int MAX_PARTICLES       = ugns_pkg::PARTICLES_DEF,
	parameter int MAX_NEIGHBOURS      = ugns_pkg::NEIGHBORS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// pos_x[15:0], pos_y[31:16], pos_z[47:32], search_radius[62:48], zero pad
	input  logic [ugns_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// func[1:0]
	input  logic [ugns_pkg::S_TUSER_W-1:0] s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// neighbor_index[9:0], overflow[10], new_index[20:11], store_full[21],
	// cell_index[33:22], in_grid[34], used_cells[47:35], binned_particles[58:48],
	// largest_cell[69:59], smallest_cell[80:70], zero pad
	output logic [ugns_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// neighbor_valid
	output logic                           m_axis_tuser,
	output logic                           m_axis_tlast
);
	import ugns_pkg::*;

	localparam int G    = GRID_CELLS_PER_AXIS;
	localparam int PW   = $clog2(MAX_PARTICLES);
	localparam int CNTW = $clog2(MAX_PARTICLES + 1);
	localparam int GW   = (G > 1) ? $clog2(G) : 1;
	localparam int NC   = G * G * G;
	localparam int CAW  = (NC > 1) ? $clog2(NC) : 1;
	localparam int HW   = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;
	localparam int KW   = $clog2(MAX_NEIGHBOURS + 1);
	localparam int OCW  = $clog2(NC + 1);
	localparam int CMW  = CNTW + 2 * PW;

	typedef enum logic [4:0] {
		ST_CLR, ST_IDLE, ST_ADD, ST_ADD_UPD, ST_Q_SETUP, ST_Q_BOUNDS, ST_Q_CELL,
		ST_Q_CELLD, ST_P_RD, ST_P_SQ, ST_P_CMP, ST_Q_DONE, ST_E_RD, ST_E_LD,
		ST_STAT_RD, ST_STAT_ACC, ST_OUT
	} state_t;

	state_t            state_q;
	in_data_t          in_q;
	logic [CNTW-1:0]   count_q;
	logic [CAW-1:0]    sweep_q;
	logic              clr_emit_q;
	logic [PW-1:0]     idx_q;
	logic [CAW-1:0]    cell_addr_q;
	logic [29:0]       rsq_q;
	logic [7:0]        w_q;
	logic [GW-1:0]     cx_q, cy_q, cz_q;
	logic [GW-1:0]     lx_q, ly_q, lz_q, hx_q, hy_q, hz_q;
	logic [GW-1:0]     x_q, y_q, z_q;
	logic              scan_q;
	logic [PW-1:0]     p_q, nxt_q;
	logic [CNTW-1:0]   j_q;
	logic [KW-1:0]     kept_q, k_q;
	logic              ovf_q;
	logic              more_q;
	logic [OCW-1:0]    st_occ_q;
	logic [CNTW-1:0]   st_bin_q, st_large_q, st_small_q;
	logic              out_valid_q, out_user_q, out_last_q;
	out_data_t         res_q;

	in_data_t          s_data;
	logic [GW:0]       ax, ay, az;
	logic              q_in_grid;
	logic [CAW-1:0]    q_cell;

	logic              cell_we;
	logic [CAW-1:0]    cell_waddr, cell_raddr;
	logic [CMW-1:0]    cell_wdata, cell_rdata;
	logic [CNTW-1:0]   cell_occ;
	logic [PW-1:0]     cell_tail, cell_head;
	logic              pos_we, next_we;
	logic [PW-1:0]     next_waddr;
	logic [47:0]       pos_rdata;
	logic [PW-1:0]     next_rdata;
	logic              hit_we;
	logic [HW-1:0]     hit_raddr;
	logic [PW-1:0]     hit_rdata;
	logic              dist_hit;

	logic              x_last, y_last, z_last, cells_done;
	logic [8:0]        cr;
	logic signed [9:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

	// Cell coordinate on one axis, floor((5p + 98304) * G / 196608), with an
	// in-range flag in the top bit. The division by 3 uses a reciprocal multiply.
	function automatic logic [GW:0] axis_cell(input logic signed [15:0] p);
		logic signed [19:0] t;
		logic [25:0]        tg;
		logic [9:0]         u;
		logic [17:0]        m;
		logic [8:0]         cf;
		t  = {{4{p[15]}}, p};
		t  = (t <<< 2) + t + 20'sd98304;
		tg = 26'(t[18:0]) * 26'(G);
		u  = tg[25:16];
		m  = 18'(u) * 18'd171;
		cf = m[17:9];
		return {(!t[19]) && (cf < 9'(G)), cf[GW-1:0]};
	endfunction

	function automatic logic [CAW-1:0] cell_addr(input logic [GW-1:0] z,
		input logic [GW-1:0] y, input logic [GW-1:0] x);
		return CAW'((32'(z) * G + 32'(y)) * G + 32'(x));
	endfunction

	function automatic logic [GW-1:0] clamp_lo(input logic signed [9:0] v);
		return v[9] ? GW'(0) : v[GW-1:0];
	endfunction

	function automatic logic [GW-1:0] clamp_hi(input logic signed [9:0] v);
		return (v > 10'(G - 1)) ? GW'(G - 1) : v[GW-1:0];
	endfunction

	assign s_data    = in_data_t'(s_axis_tdata);
	assign ax        = axis_cell(in_q.pos.x);
	assign ay        = axis_cell(in_q.pos.y);
	assign az        = axis_cell(in_q.pos.z);
	assign q_in_grid = ax[GW] && ay[GW] && az[GW];
	assign q_cell    = cell_addr(az[GW-1:0], ay[GW-1:0], ax[GW-1:0]);

	assign cell_occ  = cell_rdata[CMW-1 -: CNTW];
	assign cell_tail = cell_rdata[2*PW-1:PW];
	assign cell_head = cell_rdata[PW-1:0];

	// Cell radius: ceil(r * 5G / 196608), again by shift and reciprocal multiply.
	assign cr   = 9'((18'(w_q) * 18'd171) >> 9);
	assign lo_x = 10'(cx_q) - 10'(cr);
	assign lo_y = 10'(cy_q) - 10'(cr);
	assign lo_z = 10'(cz_q) - 10'(cr);
	assign hi_x = 10'(cx_q) + 10'(cr);
	assign hi_y = 10'(cy_q) + 10'(cr);
	assign hi_z = 10'(cz_q) + 10'(cr);

	assign x_last     = x_q == hx_q;
	assign y_last     = y_q == hy_q;
	assign z_last     = z_q == hz_q;
	assign cells_done = x_last && y_last && z_last;

	always_comb begin
		cell_we    = 1'b0;
		cell_waddr = cell_addr_q;
		cell_wdata = '0;
		cell_raddr = sweep_q;
		pos_we     = 1'b0;
		next_we    = 1'b0;
		next_waddr = cell_tail;
		hit_we     = 1'b0;
		hit_raddr  = k_q[HW-1:0];
		case (state_q)
			ST_CLR: begin
				cell_we    = 1'b1;
				cell_waddr = sweep_q;
			end
			ST_ADD: begin
				pos_we     = count_q != CNTW'(MAX_PARTICLES);
				cell_raddr = q_cell;
			end
			ST_ADD_UPD: begin
				cell_we = 1'b1;
				if (cell_occ == '0) begin
					cell_wdata = {CNTW'(1), idx_q, idx_q};
				end else begin
					cell_wdata = {cell_occ + CNTW'(1), idx_q, cell_head};
					next_we    = 1'b1;
				end
			end
			ST_Q_CELL: cell_raddr = cell_addr(z_q, y_q, x_q);
			ST_P_CMP:  hit_we = dist_hit && (kept_q < KW'(MAX_NEIGHBOURS));
			default: ;
		endcase
	end

	ugns_ram #(.WIDTH(CMW), .DEPTH(NC)) u_cell_ram (
		.clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
		.raddr(cell_raddr), .rdata(cell_rdata)
	);

	ugns_ram #(.WIDTH(48), .DEPTH(MAX_PARTICLES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(count_q[PW-1:0]), .wdata(in_q.pos),
		.raddr(p_q), .rdata(pos_rdata)
	);

	ugns_ram #(.WIDTH(PW), .DEPTH(MAX_PARTICLES)) u_next_ram (
		.clk(clk), .we(next_we), .waddr(next_waddr), .wdata(idx_q),
		.raddr(p_q), .rdata(next_rdata)
	);

	ugns_ram #(.WIDTH(PW), .DEPTH(MAX_NEIGHBOURS)) u_hit_ram (
		.clk(clk), .we(hit_we), .waddr(kept_q[HW-1:0]), .wdata(p_q),
		.raddr(hit_raddr), .rdata(hit_rdata)
	);

	ugns_dist u_dist (
		.clk(clk), .a(coord_t'(pos_rdata)), .b(in_q.pos), .rsq(rsq_q), .hit(dist_hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			in_q        <= '0;
			count_q     <= '0;
			sweep_q     <= '0;
			clr_emit_q  <= 1'b0;
			idx_q       <= '0;
			cell_addr_q <= '0;
			rsq_q       <= '0;
			w_q         <= '0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			lx_q <= '0; ly_q <= '0; lz_q <= '0;
			hx_q <= '0; hy_q <= '0; hz_q <= '0;
			x_q  <= '0; y_q  <= '0; z_q  <= '0;
			scan_q      <= 1'b0;
			p_q         <= '0;
			nxt_q       <= '0;
			j_q         <= '0;
			kept_q      <= '0;
			k_q         <= '0;
			ovf_q       <= 1'b0;
			more_q      <= 1'b0;
			st_occ_q    <= '0;
			st_bin_q    <= '0;
			st_large_q  <= '0;
			st_small_q  <= '0;
			out_valid_q <= 1'b0;
			out_user_q  <= 1'b0;
			out_last_q  <= 1'b0;
			res_q       <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					sweep_q <= sweep_q + CAW'(1);
					if (sweep_q == CAW'(NC - 1)) begin
						if (clr_emit_q) begin
							res_q       <= '0;
							out_user_q  <= 1'b0;
							out_last_q  <= 1'b1;
							out_valid_q <= 1'b1;
							more_q      <= 1'b0;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						in_q       <= s_data;
						sweep_q    <= '0;
						st_occ_q   <= '0;
						st_bin_q   <= '0;
						st_large_q <= '0;
						st_small_q <= '0;
						case (func_t'(s_axis_tuser))
							FUNC_CLEAR: begin
								count_q    <= '0;
								clr_emit_q <= 1'b1;
								state_q    <= ST_CLR;
							end
							FUNC_ADD:   state_q <= ST_ADD;
							FUNC_QUERY: state_q <= ST_Q_SETUP;
							FUNC_STATS: state_q <= ST_STAT_RD;
							default:    state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ADD: begin
					out_user_q  <= 1'b0;
					out_last_q  <= 1'b1;
					more_q      <= 1'b0;
					idx_q       <= count_q[PW-1:0];
					cell_addr_q <= q_cell;
					if (count_q == CNTW'(MAX_PARTICLES)) begin
						res_q       <= '{store_full: 1'b1, default: '0};
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						count_q <= count_q + CNTW'(1);
						res_q   <= '{new_index: IDX_W'(count_q[PW-1:0]), default: '0};
						if (q_in_grid) begin
							state_q <= ST_ADD_UPD;
						end else begin
							out_valid_q <= 1'b1;
							state_q     <= ST_OUT;
						end
					end
				end
				ST_ADD_UPD: begin
					res_q       <= '{new_index: res_q.new_index,
						cell_index: CELL_W'(cell_addr_q), in_grid: 1'b1, default: '0};
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_Q_SETUP: begin
					rsq_q  <= 30'(in_q.search_radius) * 30'(in_q.search_radius);
					w_q    <= 8'((24'(in_q.search_radius) * 24'(5 * G) + 24'd196607) >> 16);
					cx_q   <= ax[GW-1:0];
					cy_q   <= ay[GW-1:0];
					cz_q   <= az[GW-1:0];
					kept_q <= '0;
					ovf_q  <= 1'b0;
					scan_q <= !q_in_grid;
					if (!q_in_grid) begin
						p_q     <= '0;
						j_q     <= count_q;
						state_q <= (count_q == '0) ? ST_Q_DONE : ST_P_RD;
					end else begin
						state_q <= ST_Q_BOUNDS;
					end
				end
				ST_Q_BOUNDS: begin
					lx_q <= clamp_lo(lo_x); ly_q <= clamp_lo(lo_y); lz_q <= clamp_lo(lo_z);
					hx_q <= clamp_hi(hi_x); hy_q <= clamp_hi(hi_y); hz_q <= clamp_hi(hi_z);
					x_q  <= clamp_lo(lo_x); y_q  <= clamp_lo(lo_y); z_q  <= clamp_lo(lo_z);
					state_q <= ST_Q_CELL;
				end
				ST_Q_CELL: state_q <= ST_Q_CELLD;
				ST_Q_CELLD: begin
					if (cell_occ != '0) begin
						p_q     <= cell_head;
						j_q     <= cell_occ;
						state_q <= ST_P_RD;
					end else if (cells_done) begin
						state_q <= ST_Q_DONE;
					end else begin
						x_q     <= x_last ? lx_q : x_q + GW'(1);
						y_q     <= x_last ? (y_last ? ly_q : y_q + GW'(1)) : y_q;
						z_q     <= (x_last && y_last) ? z_q + GW'(1) : z_q;
						state_q <= ST_Q_CELL;
					end
				end
				ST_P_RD: state_q <= ST_P_SQ;
				ST_P_SQ: begin
					nxt_q   <= next_rdata;
					state_q <= ST_P_CMP;
				end
				ST_P_CMP: begin
					if (dist_hit) begin
						if (kept_q < KW'(MAX_NEIGHBOURS)) begin
							kept_q <= kept_q + KW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					j_q <= j_q - CNTW'(1);
					p_q <= scan_q ? p_q + PW'(1) : nxt_q;
					if (j_q != CNTW'(1)) begin
						state_q <= ST_P_RD;
					end else if (scan_q || cells_done) begin
						state_q <= ST_Q_DONE;
					end else begin
						x_q     <= x_last ? lx_q : x_q + GW'(1);
						y_q     <= x_last ? (y_last ? ly_q : y_q + GW'(1)) : y_q;
						z_q     <= (x_last && y_last) ? z_q + GW'(1) : z_q;
						state_q <= ST_Q_CELL;
					end
				end
				ST_Q_DONE: begin
					k_q <= '0;
					if (kept_q == '0) begin
						res_q       <= '0;
						out_user_q  <= 1'b0;
						out_last_q  <= 1'b1;
						out_valid_q <= 1'b1;
						more_q      <= 1'b0;
						state_q     <= ST_OUT;
					end else begin
						state_q <= ST_E_RD;
					end
				end
				ST_E_RD: state_q <= ST_E_LD;
				ST_E_LD: begin
					res_q       <= '{neighbor_index: IDX_W'(hit_rdata), overflow: ovf_q,
						default: '0};
					out_user_q  <= 1'b1;
					out_last_q  <= (k_q + KW'(1)) == kept_q;
					more_q      <= (k_q + KW'(1)) != kept_q;
					out_valid_q <= 1'b1;
					k_q         <= k_q + KW'(1);
					state_q     <= ST_OUT;
				end
				ST_STAT_RD: state_q <= ST_STAT_ACC;
				ST_STAT_ACC: begin
					if (cell_occ != '0) begin
						if (st_occ_q == '0 || cell_occ < st_small_q) begin
							st_small_q <= cell_occ;
						end
						if (cell_occ > st_large_q) begin
							st_large_q <= cell_occ;
						end
						st_occ_q <= st_occ_q + OCW'(1);
						st_bin_q <= st_bin_q + cell_occ;
					end
					sweep_q <= sweep_q + CAW'(1);
					if (sweep_q == CAW'(NC - 1)) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
						out_user_q  <= 1'b0;
						out_last_q  <= 1'b1;
						more_q      <= 1'b0;
						// The last cell is folded in here as well.
						if (cell_occ != '0) begin
							res_q <= '{used_cells: OCC_W'(st_occ_q + OCW'(1)),
								binned_particles: CNT_W'(st_bin_q + cell_occ),
								largest_cell: CNT_W'((cell_occ > st_large_q) ?
									cell_occ : st_large_q),
								smallest_cell: CNT_W'((st_occ_q == '0 ||
									cell_occ < st_small_q) ? cell_occ : st_small_q),
								default: '0};
						end else begin
							res_q <= '{used_cells: OCC_W'(st_occ_q),
								binned_particles: CNT_W'(st_bin_q),
								largest_cell: CNT_W'(st_large_q),
								smallest_cell: CNT_W'(st_small_q),
								default: '0};
						end
					end else begin
						state_q <= ST_STAT_RD;
					end
				end
				ST_OUT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						state_q     <= more_q ? ST_E_RD : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	a_out_only_in_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT)
		else $error("result valid outside the output state");

	a_no_accept_while_pending: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("input ready while a result is pending");

	a_kept_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= KW'(MAX_NEIGHBOURS))
		else $error("hit buffer count beyond its depth");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_PARTICLES))
		else $error("particle count beyond the store size");
endmodule

// ===== rtl/ugns_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ugns_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/ugns_dist.sv =====
`timescale 1ns / 1ps
// Squared distance unit: registers the three squared differences, then
// compares their sum against the squared radius. Depends on ugns_pkg.
module ugns_dist (
	input  logic             clk,
	input  ugns_pkg::coord_t a,
	input  ugns_pkg::coord_t b,
	input  logic [29:0]      rsq,
	output logic             hit
);
	import ugns_pkg::*;

	logic signed [16:0] dx, dy, dz;
	logic [33:0] sqx_s1, sqy_s1, sqz_s1;
	logic [35:0] sum;

	assign dx = 17'(a.x) - 17'(b.x);
	assign dy = 17'(a.y) - 17'(b.y);
	assign dz = 17'(a.z) - 17'(b.z);

	always_ff @(posedge clk) begin
		sqx_s1 <= 34'(dx) * 34'(dx);
		sqy_s1 <= 34'(dy) * 34'(dy);
		sqz_s1 <= 34'(dz) * 34'(dz);
	end

	assign sum = 36'(sqx_s1) + 36'(sqy_s1) + 36'(sqz_s1);
	assign hit = sum < 36'(rsq);
endmodule
